/* hdl/ltde_pkg.sv */
`default_nettype none

package ltde_pkg;

   // Address delta is taken modulo 2^ADDR_WIDTH (16 to 64).
   localparam int ADDR_WIDTH = 32;

   localparam int AddrFieldWidth = 32;
   localparam int LineWidth      = 31;
   localparam int FileWidth      = 16;
   localparam int LineDeltaWidth = LineWidth + 1;
   localparam int FileIncWidth   = FileWidth + 1;

   // Address bits that survive the modulo; the field itself is 32 bits wide.
   localparam int AddrKeep = (ADDR_WIDTH < AddrFieldWidth) ? ADDR_WIDTH : AddrFieldWidth;
   // Width of the working value of the LEB128 unit.
   localparam int ValWidth = (ADDR_WIDTH > LineDeltaWidth) ? ADDR_WIDTH : LineDeltaWidth;

   localparam logic [7:0] OpCopy     = 8'h01;
   localparam logic [7:0] OpAdvPc    = 8'h02;
   localparam logic [7:0] OpAdvLine  = 8'h03;
   localparam logic [7:0] OpSetFile  = 8'h04;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_PC_OP,
      ST_PC_LEB,
      ST_LINE_OP,
      ST_LINE_LEB,
      ST_FILE_OP,
      ST_FILE_LEB,
      ST_COPY
   } state_type;

   typedef struct packed {
      logic [7:0]          data;
      logic                last;
      logic [ValWidth-1:0] rest;
   } leb_out_type;

endpackage

`default_nettype wire

/* hdl/ltde_if.sv */
`default_nettype none

interface ltde_req_if;
   logic                                 valid;
   logic                                 ready;
   logic [ltde_pkg::AddrFieldWidth-1:0]  code_address;
   logic [ltde_pkg::LineWidth-1:0]       source_line;
   logic [ltde_pkg::FileWidth-1:0]       file_number;

   modport source (output valid, code_address, source_line, file_number, input ready);
   modport sink   (input valid, code_address, source_line, file_number, output ready);
endinterface

interface ltde_rsp_if;
   logic       valid;
   logic       ready;
   logic [7:0] out_byte;
   logic       row_end;

   modport source (output valid, out_byte, row_end, input ready);
   modport sink   (input valid, out_byte, row_end, output ready);
endinterface

`default_nettype wire

/* hdl/ltde_leb_unit.sv */
`default_nettype none

// One LEB128 step: the low seven bits of the value, the continuation flag
// and the value shifted down by seven for the next step.
module ltde_leb_unit (
   input  wire logic [ltde_pkg::ValWidth-1:0] value,
   input  wire logic                          is_signed,
   output ltde_pkg::leb_out_type              result
);

   logic [ltde_pkg::ValWidth-8:0] upper;
   logic                          last;

   assign upper = value[ltde_pkg::ValWidth-1:7];

   always_comb begin
      if (is_signed) begin
         // Done once every bit above the payload equals its sign bit.
         last = value[6] ? (&upper) : (upper == '0);
      end else begin
         last = (upper == '0);
      end
      result.last = last;
      result.data = {~last, value[6:0]};
      if (is_signed) begin
         result.rest = ltde_pkg::ValWidth'($signed(value) >>> 7);
      end else begin
         result.rest = value >> 7;
      end
   end

endmodule

`default_nettype wire

/* hdl/line_table_delta_encoder_unit.sv */
`default_nettype none

// Channel  Direction  Beat contents
// req      in         code_address, source_line, file_number (one line-table row)
// rsp      out        out_byte, row_end (one byte of the line program)
//
// A row of N output bytes (5 to 17 at the default address width) is accepted
// in ST_IDLE; the sequencer then issues one byte per cycle while rsp is not
// stalled, running every LEB128 byte through the single shared encoder step.
// Reset is synchronous; it clears the sequencer, the output valid flag and the
// previous row state (address 0, line 1, file 0). While rsp is stalled the
// sequencer holds; req is ready only between rows.
module line_table_delta_encoder_unit (
   input wire logic  clock,
   input wire logic  reset,
   ltde_req_if.sink  req_ch,
   ltde_rsp_if.source rsp_ch
);

   ltde_pkg::state_type                     state_ff, state_in;
   logic [ltde_pkg::ValWidth-1:0]           val_ff, val_in;
   logic signed [ltde_pkg::LineDeltaWidth-1:0] line_delta_ff, line_delta_in;
   logic                                    file_chg_ff, file_chg_in;
   logic [ltde_pkg::FileIncWidth-1:0]       file_inc_ff, file_inc_in;

   logic [ltde_pkg::AddrKeep-1:0]           prev_addr_ff;
   logic [ltde_pkg::LineWidth-1:0]          prev_line_ff;
   logic [ltde_pkg::FileWidth-1:0]          prev_file_ff;

   logic                                    out_valid_ff, out_valid_in;
   logic [7:0]                              out_byte_ff, out_byte_in;
   logic                                    out_end_ff, out_end_in;

   logic                                    accept;
   logic                                    out_free;
   logic                                    leb_signed;
   ltde_pkg::leb_out_type                   leb;
   logic [ltde_pkg::AddrKeep-1:0]           addr_keep;
   logic [ltde_pkg::ADDR_WIDTH-1:0]         addr_delta;

   ltde_leb_unit u_leb (
      .value     (val_ff),
      .is_signed (leb_signed),
      .result    (leb)
   );

   assign req_ch.ready    = (state_ff == ltde_pkg::ST_IDLE);
   assign accept          = req_ch.valid && req_ch.ready;
   assign out_free        = !out_valid_ff || rsp_ch.ready;
   assign leb_signed      = (state_ff == ltde_pkg::ST_LINE_LEB);

   assign rsp_ch.valid    = out_valid_ff;
   assign rsp_ch.out_byte = out_byte_ff;
   assign rsp_ch.row_end  = out_end_ff;

   assign addr_keep  = req_ch.code_address[ltde_pkg::AddrKeep-1:0];
   assign addr_delta = ltde_pkg::ADDR_WIDTH'(addr_keep)
                     - ltde_pkg::ADDR_WIDTH'(prev_addr_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ltde_pkg::ST_IDLE;
         out_valid_ff <= 1'b0;
         prev_addr_ff <= '0;
         prev_line_ff <= ltde_pkg::LineWidth'(1);
         prev_file_ff <= '0;
      end else begin
         state_ff     <= state_in;
         out_valid_ff <= out_valid_in;
         if (accept) begin
            prev_addr_ff <= addr_keep;
            prev_line_ff <= req_ch.source_line;
            prev_file_ff <= req_ch.file_number;
         end
      end
   end

   always_ff @(posedge clock) begin
      val_ff        <= val_in;
      line_delta_ff <= line_delta_in;
      file_chg_ff   <= file_chg_in;
      file_inc_ff   <= file_inc_in;
      out_byte_ff   <= out_byte_in;
      out_end_ff    <= out_end_in;
   end

   always_comb begin
      logic emit;
      logic [7:0] emit_byte;
      logic emit_end;

      emit          = 1'b0;
      emit_byte     = ltde_pkg::OpCopy;
      emit_end      = 1'b0;
      state_in      = state_ff;
      val_in        = val_ff;
      line_delta_in = line_delta_ff;
      file_chg_in   = file_chg_ff;
      file_inc_in   = file_inc_ff;

      unique case (state_ff)
         ltde_pkg::ST_IDLE: begin
            if (accept) begin
               val_in        = ltde_pkg::ValWidth'(addr_delta);
               line_delta_in = $signed({1'b0, req_ch.source_line})
                             - $signed({1'b0, prev_line_ff});
               file_chg_in   = (req_ch.file_number != prev_file_ff);
               file_inc_in   = {1'b0, req_ch.file_number} + ltde_pkg::FileIncWidth'(1);
               state_in      = ltde_pkg::ST_PC_OP;
            end
         end
         ltde_pkg::ST_PC_OP: begin
            emit      = 1'b1;
            emit_byte = ltde_pkg::OpAdvPc;
            if (out_free) begin
               state_in = ltde_pkg::ST_PC_LEB;
            end
         end
         ltde_pkg::ST_PC_LEB: begin
            emit      = 1'b1;
            emit_byte = leb.data;
            if (out_free) begin
               val_in = leb.rest;
               if (leb.last) begin
                  state_in = ltde_pkg::ST_LINE_OP;
               end
            end
         end
         ltde_pkg::ST_LINE_OP: begin
            emit      = 1'b1;
            emit_byte = ltde_pkg::OpAdvLine;
            if (out_free) begin
               // Size cast of a signed value sign-extends it.
               val_in   = ltde_pkg::ValWidth'(line_delta_ff);
               state_in = ltde_pkg::ST_LINE_LEB;
            end
         end
         ltde_pkg::ST_LINE_LEB: begin
            emit      = 1'b1;
            emit_byte = leb.data;
            if (out_free) begin
               val_in = leb.rest;
               if (leb.last) begin
                  state_in = file_chg_ff ? ltde_pkg::ST_FILE_OP : ltde_pkg::ST_COPY;
               end
            end
         end
         ltde_pkg::ST_FILE_OP: begin
            emit      = 1'b1;
            emit_byte = ltde_pkg::OpSetFile;
            if (out_free) begin
               val_in   = ltde_pkg::ValWidth'(file_inc_ff);
               state_in = ltde_pkg::ST_FILE_LEB;
            end
         end
         ltde_pkg::ST_FILE_LEB: begin
            emit      = 1'b1;
            emit_byte = leb.data;
            if (out_free) begin
               val_in = leb.rest;
               if (leb.last) begin
                  state_in = ltde_pkg::ST_COPY;
               end
            end
         end
         ltde_pkg::ST_COPY: begin
            emit      = 1'b1;
            emit_byte = ltde_pkg::OpCopy;
            emit_end  = 1'b1;
            if (out_free) begin
               state_in = ltde_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = ltde_pkg::ST_IDLE;
         end
      endcase

      // The output register takes a new beat only once the last one has left.
      if (emit && out_free) begin
         out_valid_in = 1'b1;
         out_byte_in  = emit_byte;
         out_end_in   = emit_end;
      end else begin
         out_valid_in = out_valid_ff && !rsp_ch.ready;
         out_byte_in  = out_byte_ff;
         out_end_in   = out_end_ff;
      end
   end

endmodule

`default_nettype wire

/* verif/line_table_delta_encoder_unit_tb.sv */
module line_table_delta_encoder_unit_tb;
   timeunit 1ns;
   timeprecision 1ps;

   typedef struct packed {
      logic [7:0] data;
      logic       row_end;
   } prog_byte_type;

   typedef enum int {
      STALL_NONE,
      STALL_LIGHT,
      STALL_PERIODIC,
      STALL_HEAVY
   } stall_mode_type;

   localparam logic [63:0] AddrMask = (ltde_pkg::ADDR_WIDTH >= 64) ? {64{1'b1}} :
                                      ((64'd1 << ltde_pkg::ADDR_WIDTH) - 64'd1);
   localparam int RandomRows = 407;
   localparam int DrainCycles = 40;

   logic clock;
   logic reset;

   ltde_req_if req_bus ();
   ltde_rsp_if rsp_bus ();

   line_table_delta_encoder_unit DUT (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_bus),
      .rsp_ch (rsp_bus)
   );

   // Line-program state as the encoder should hold it after each accepted row.
   logic [63:0] last_address = 64'd0;
   logic [30:0] last_line    = 31'd1;
   logic [15:0] last_file    = 16'd0;

   prog_byte_type line_program_due[$];
   int            mismatch_count = 0;

   // Sender burst bookkeeping.
   int burst_left = 0;

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   initial begin
      #1ms;
      $display("CHECK FAILED");
      $finish;
   end

   function automatic void push_program_byte(input logic [7:0] data, input logic row_end);
      prog_byte_type b;
      b.data = data;
      b.row_end = row_end;
      line_program_due = {line_program_due, b};
   endfunction

   function automatic void push_uleb(input logic [63:0] value);
      logic [63:0] v;
      v = value;
      while (v > 64'h7F) begin
         push_program_byte({1'b1, v[6:0]}, 1'b0);
         v = v >> 7;
      end
      push_program_byte({1'b0, v[6:0]}, 1'b0);
   endfunction

   function automatic void predict_line_program(input logic [31:0] addr,
                                                input logic [30:0] line,
                                                input logic [15:0] file);
      logic [63:0]        addr_kept;
      logic signed [63:0] line_delta;
      logic               done;
      addr_kept = {32'd0, addr} & AddrMask;
      push_program_byte(ltde_pkg::OpAdvPc, 1'b0);
      push_uleb((addr_kept - last_address) & AddrMask);
      last_address = addr_kept;

      push_program_byte(ltde_pkg::OpAdvLine, 1'b0);
      line_delta = $signed({33'd0, line}) - $signed({33'd0, last_line});
      done = 1'b0;
      // Signed LEB128 stops once the remaining bits are pure sign extension of bit 6.
      while (!done) begin
         if (((line_delta >>> 7) == 64'sd0 && !line_delta[6]) ||
             ((line_delta >>> 7) == -64'sd1 && line_delta[6])) begin
            push_program_byte({1'b0, line_delta[6:0]}, 1'b0);
            done = 1'b1;
         end else begin
            push_program_byte({1'b1, line_delta[6:0]}, 1'b0);
            line_delta = line_delta >>> 7;
         end
      end
      last_line = line;

      if (file != last_file) begin
         push_program_byte(ltde_pkg::OpSetFile, 1'b0);
         push_uleb({48'd0, file} + 64'd1);
         last_file = file;
      end

      push_program_byte(ltde_pkg::OpCopy, 1'b1);
   endfunction

   // Called right after a falling edge; returns right after the falling edge that
   // follows acceptance, with valid still high.
   task automatic send_row(input logic [31:0] addr, input logic [30:0] line,
                           input logic [15:0] file);
      int gap;
      if (burst_left == 0) begin
         burst_left = $urandom_range(1, 12);
         gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
         if (gap > 0) begin
            req_bus.valid <= 1'b0;
            repeat (gap) @(negedge clock);
         end
      end
      burst_left--;
      req_bus.valid        <= 1'b1;
      req_bus.code_address <= addr;
      req_bus.source_line  <= line;
      req_bus.file_number  <= file;
      @(posedge clock);
      while (!req_bus.ready) @(posedge clock);
      predict_line_program(addr, line, file);
      @(negedge clock);
   endtask

   task automatic test_first_rows();
      send_row(32'd0, 31'd1, 16'd0);
      send_row(32'd1, 31'd2, 16'd0);
   endtask

   // Deltas on either side of the one- and two-byte LEB128 limits.
   task automatic test_leb_boundaries();
      send_row(last_address[31:0] + 32'd127, last_line + 31'd63, last_file);
      send_row(last_address[31:0] + 32'd128, last_line + 31'd64, last_file);
      send_row(last_address[31:0] + 32'd16383, last_line - 31'd64, last_file);
      send_row(last_address[31:0] + 32'd16384, last_line - 31'd65, last_file);
      send_row(last_address[31:0], last_line, last_file);
   endtask

   task automatic test_address_wrap();
      send_row(32'hFFFF_FFFF, last_line, last_file);
      send_row(32'd0, last_line, last_file);
      send_row(32'd5, last_line, last_file);
      send_row(32'd4, last_line, last_file);
   endtask

   task automatic test_line_backward();
      send_row(last_address[31:0], 31'h7FFF_FFFF, last_file);
      send_row(last_address[31:0], 31'd0, last_file);
      send_row(last_address[31:0], 31'd0, last_file);
      send_row(last_address[31:0], 31'd1, last_file);
      send_row(last_address[31:0], 31'd0, last_file);
   endtask

   task automatic test_file_switch();
      send_row(last_address[31:0], last_line, 16'hFFFF);
      send_row(last_address[31:0], last_line, 16'd0);
      send_row(last_address[31:0], last_line, 16'd0);
      send_row(last_address[31:0], last_line, 16'd127);
      send_row(last_address[31:0], last_line, 16'd126);
   endtask

   // Backward address, full-range line jump and a three-byte file code at once.
   task automatic test_longest_row();
      send_row(last_address[31:0] - 32'd1, 31'h7FFF_FFFF, 16'hFFFF);
      send_row(last_address[31:0] - 32'd1, 31'd0, 16'd0);
   endtask

   task automatic test_random_rows(input int rows);
      logic [31:0] addr;
      longint      line;
      logic [15:0] file;
      for (int i = 0; i < rows; i++) begin
         if ($urandom_range(0, 4) == 0) begin
            addr = $urandom();
            line = longint'($urandom() & 32'h7FFF_FFFF);
            file = ($urandom_range(0, 1) == 1) ? 16'($urandom()) : last_file;
         end else begin
            // Compiler-like rows: address creeps forward, line wanders locally.
            addr = last_address[31:0] + (($urandom_range(0, 9) == 0) ?
                   $urandom_range(0, 100000) : $urandom_range(0, 64));
            line = longint'(last_line) + longint'(int'($urandom_range(0, 60)) - 20);
            if (line < 0)
               line = 0;
            if (line > 64'sh7FFF_FFFF)
               line = 64'sh7FFF_FFFF;
            file = ($urandom_range(0, 7) == 0) ? 16'($urandom_range(0, 40)) : last_file;
         end
         send_row(addr, 31'(line), file);
      end
   endtask

   // Receiver stalls follow a randomly chosen mode that is redrawn when its random span runs out.
   initial begin
      stall_mode_type mode;
      int             mode_left;
      int             tick;
      mode = STALL_NONE;
      mode_left = 0;
      tick = 0;
      rsp_bus.ready = 1'b0;
      forever begin
         @(negedge clock);
         if (mode_left == 0) begin
            mode = stall_mode_type'($urandom_range(0, 3));
            mode_left = $urandom_range(30, 200);
         end
         mode_left--;
         tick++;
         case (mode)
            STALL_NONE: begin
               rsp_bus.ready <= 1'b1;
            end
            STALL_LIGHT: begin
               rsp_bus.ready <= ($urandom_range(0, 3) != 0);
            end
            STALL_PERIODIC: begin
               rsp_bus.ready <= ((tick % 5) < 3);
            end
            default: begin
               rsp_bus.ready <= ($urandom_range(0, 3) == 0);
            end
         endcase
      end
   end

   always @(posedge clock) begin : check_bytes
      prog_byte_type due;
      if (!reset && rsp_bus.valid && rsp_bus.ready) begin
         if (line_program_due.size() == 0) begin
            $display("%0t ns: byte with none expected, actual %h row_end %b",
                     $time, rsp_bus.out_byte, rsp_bus.row_end);
            mismatch_count++;
         end else begin
            due = line_program_due.pop_front();
            if (rsp_bus.out_byte !== due.data) begin
               $display("%0t ns: out_byte expected %h actual %h",
                        $time, due.data, rsp_bus.out_byte);
               mismatch_count++;
            end
            if (rsp_bus.row_end !== due.row_end) begin
               $display("%0t ns: row_end expected %b actual %b",
                        $time, due.row_end, rsp_bus.row_end);
               mismatch_count++;
            end
         end
      end
   end

   initial begin
      reset = 1'b1;
      req_bus.valid = 1'b0;
      req_bus.code_address = '0;
      req_bus.source_line = '0;
      req_bus.file_number = '0;
      repeat (11) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      test_first_rows();
      test_leb_boundaries();
      test_address_wrap();
      test_line_backward();
      test_file_switch();
      test_longest_row();
      test_random_rows(RandomRows);
      req_bus.valid <= 1'b0;

      while (line_program_due.size() != 0) @(posedge clock);
      repeat (DrainCycles) @(posedge clock);

      if (mismatch_count == 0 && line_program_due.size() == 0) begin
         $display("CHECK OK");
      end else begin
         $display("CHECK FAILED");
      end
      $finish;
   end

endmodule
